FILE: src/sfu_pkg.sv
package sfu_pkg;

  localparam int COORD_W  = 24;
  localparam int SPEED_W  = 16;
  localparam int RADIUS_W = 23;

  // Internal widths; all but PRED_Q_W follow from the field widths above.
  localparam int DIFF_W     = COORD_W + 1;            // position difference
  localparam int ROOT_W     = DIFF_W + 1;             // distance
  localparam int RAD_W      = 2 * ROOT_W;             // sum of squares
  localparam int QUO_W      = SPEED_W + 1;            // scaled direction magnitude
  localparam int VEL_W      = QUO_W + 1;              // signed desired velocity
  localparam int AIM_NUM_W  = ROOT_W + QUO_W + 1;
  localparam int ARR_NUM_W  = RADIUS_W + QUO_W + 2;
  localparam int PRED_Q_W   = 35;                     // covers the 2^34 clamp
  localparam int PRED_NUM_W = PRED_Q_W + SPEED_W + 1;
  localparam int OFS_W      = PRED_Q_W + 1;

  typedef enum logic [1:0] {
    CMD_SEEK    = 2'd0,
    CMD_FLEE    = 2'd1,
    CMD_PURSUIT = 2'd2,
    CMD_EVADE   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                      command;
    logic signed [COORD_W-1:0] self_x;
    logic signed [COORD_W-1:0] self_y;
    logic signed [COORD_W-1:0] self_vx;
    logic signed [COORD_W-1:0] self_vy;
    logic [SPEED_W-1:0]        max_speed;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic signed [COORD_W-1:0] target_vx;
    logic signed [COORD_W-1:0] target_vy;
  } in_beat_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] force_x;
    logic signed [COORD_W-1:0] force_y;
  } out_beat_t;

endpackage

FILE: src/sfu_div_cell.sv
module sfu_div_cell #(
  parameter int NUM_W  = 8,
  parameter int DEN_W  = 4,
  parameter int QUO_W  = 4,
  parameter int SHIFT  = 0,
  parameter int SIDE_W = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   vld_i,
  input  logic [1:0][NUM_W-1:0]  rem_i,
  input  logic [1:0][QUO_W-1:0]  quo_i,
  input  logic [DEN_W-1:0]       den_i,
  input  logic [SIDE_W-1:0]      side_i,
  output logic                   vld_o,
  output logic [1:0][NUM_W-1:0]  rem_o,
  output logic [1:0][QUO_W-1:0]  quo_o,
  output logic [DEN_W-1:0]       den_o,
  output logic [SIDE_W-1:0]      side_o
);

  logic                  vld_r;
  logic [1:0][NUM_W-1:0] rem_r, rem_nxt;
  logic [1:0][QUO_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0]      den_r;
  logic [SIDE_W-1:0]     side_r;
  logic [NUM_W-1:0]      trial;

  assign trial = NUM_W'(den_i) << SHIFT;

  // One restoring step for both lanes against the shared divisor.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rem_nxt[l] = rem_i[l];
      quo_nxt[l] = quo_i[l];
      if (rem_i[l] >= trial) begin
        rem_nxt[l]        = rem_i[l] - trial;
        quo_nxt[l][SHIFT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      den_r  <= den_i;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign quo_o  = quo_r;
  assign den_o  = den_r;
  assign side_o = side_r;

endmodule

FILE: src/sfu_div.sv
module sfu_div #(
  parameter int NUM_W  = 8,
  parameter int DEN_W  = 4,
  parameter int QUO_W  = 4,
  parameter int SIDE_W = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   vld_i,
  input  logic [1:0][NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]       den_i,
  input  logic [SIDE_W-1:0]      side_i,
  output logic                   vld_o,
  output logic [1:0][QUO_W-1:0]  quo_o,
  output logic [SIDE_W-1:0]      side_o
);

  logic [QUO_W:0]                   vld;
  logic [QUO_W:0][1:0][NUM_W-1:0]   rem;
  logic [QUO_W:0][1:0][QUO_W-1:0]   quo;
  logic [QUO_W:0][DEN_W-1:0]        den;
  logic [QUO_W:0][SIDE_W-1:0]       side;

  assign vld[0]  = vld_i;
  assign rem[0]  = num_i;
  assign quo[0]  = '0;
  assign den[0]  = den_i;
  assign side[0] = side_i;

  // Quotient bits are resolved from the top down, one bit per cell.
  for (genvar k = 0; k < QUO_W; k++) begin : g_cell
    sfu_div_cell #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .QUO_W (QUO_W),
      .SHIFT (QUO_W - 1 - k),
      .SIDE_W(SIDE_W)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (vld[k]),
      .rem_i (rem[k]),
      .quo_i (quo[k]),
      .den_i (den[k]),
      .side_i(side[k]),
      .vld_o (vld[k+1]),
      .rem_o (rem[k+1]),
      .quo_o (quo[k+1]),
      .den_o (den[k+1]),
      .side_o(side[k+1])
    );
  end

  assign vld_o  = vld[QUO_W];
  assign quo_o  = quo[QUO_W];
  assign side_o = side[QUO_W];

endmodule

FILE: src/sfu_sqrt_cell.sv
module sfu_sqrt_cell #(
  parameter int RAD_W  = 8,
  parameter int K      = 0,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  logic [RAD_W-1:0]  n_i,
  input  logic [RAD_W-1:0]  r_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [RAD_W-1:0]  n_o,
  output logic [RAD_W-1:0]  r_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * K);

  logic              vld_r;
  logic [RAD_W-1:0]  n_r, n_nxt, r_r, r_nxt, trial;
  logic [SIDE_W-1:0] side_r;

  assign trial = r_i + BIT;

  always_comb begin
    if (n_i >= trial) begin
      n_nxt = n_i - trial;
      r_nxt = (r_i >> 1) + BIT;
    end else begin
      n_nxt = n_i;
      r_nxt = r_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r    <= n_nxt;
      r_r    <= r_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign n_o    = n_r;
  assign r_o    = r_r;
  assign side_o = side_r;

endmodule

FILE: src/sfu_aim.sv
module sfu_aim #(
  parameter int SIDE_W = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              vld_i,
  input  logic signed [sfu_pkg::DIFF_W-1:0] dx_i,
  input  logic signed [sfu_pkg::DIFF_W-1:0] dy_i,
  input  logic [sfu_pkg::SPEED_W-1:0]       ms_i,
  input  logic [SIDE_W-1:0]                 side_i,
  output logic                              vld_o,
  output logic signed [sfu_pkg::VEL_W-1:0]  wx_o,
  output logic signed [sfu_pkg::VEL_W-1:0]  wy_o,
  output logic [sfu_pkg::ROOT_W-1:0]        len_o,
  output logic [SIDE_W-1:0]                 side_o
);
  import sfu_pkg::*;

  typedef struct packed {
    logic [SIDE_W-1:0]  user;
    logic [DIFF_W-1:0]  bx;
    logic [DIFF_W-1:0]  by;
    logic               nx;
    logic               ny;
    logic [SPEED_W-1:0] ms;
  } rt_side_t;

  typedef struct packed {
    logic [SIDE_W-1:0] user;
    logic              nx;
    logic              ny;
    logic [ROOT_W-1:0] ls;
  } dv_side_t;

  localparam int RT_W = $bits(rt_side_t);
  localparam int DV_W = $bits(dv_side_t);

  // Magnitudes and signs.
  logic     a1_vld_r;
  rt_side_t a1_r;
  // Squares.
  logic                  a2_vld_r;
  rt_side_t              a2_r;
  logic [2*DIFF_W-1:0]   sqx_r, sqy_r;
  // Sum of squares.
  logic       a3_vld_r;
  rt_side_t   a3_r;
  logic [RAD_W-1:0] sum_r;

  logic [ROOT_W:0]              rt_vld;
  logic [ROOT_W:0][RAD_W-1:0]   rt_n, rt_r;
  logic [ROOT_W:0][RT_W-1:0]    rt_side;
  rt_side_t                     rt_out;

  // Direction times speed.
  logic                        a4_vld_r;
  dv_side_t                    a4_r;
  logic [DIFF_W+SPEED_W-1:0]   pmx_r, pmy_r;
  // Rounding offset added.
  logic                        a5_vld_r;
  dv_side_t                    a5_r;
  logic [1:0][AIM_NUM_W-1:0]   num_r;

  logic                        dv_vld;
  logic [1:0][QUO_W-1:0]       dv_quo;
  logic [DV_W-1:0]             dv_side;
  dv_side_t                    dv_out;

  logic                        a6_vld_r;
  logic signed [VEL_W-1:0]     wx_r, wy_r;
  logic [ROOT_W-1:0]           len_r;
  logic [SIDE_W-1:0]           user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1_vld_r <= 1'b0;
      a2_vld_r <= 1'b0;
      a3_vld_r <= 1'b0;
      a4_vld_r <= 1'b0;
      a5_vld_r <= 1'b0;
      a6_vld_r <= 1'b0;
    end else if (en) begin
      a1_vld_r <= vld_i;
      a2_vld_r <= a1_vld_r;
      a3_vld_r <= a2_vld_r;
      a4_vld_r <= rt_vld[ROOT_W];
      a5_vld_r <= a4_vld_r;
      a6_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r.user <= side_i;
      a1_r.nx   <= dx_i[DIFF_W-1];
      a1_r.ny   <= dy_i[DIFF_W-1];
      a1_r.bx   <= dx_i[DIFF_W-1] ? DIFF_W'(-dx_i) : DIFF_W'(dx_i);
      a1_r.by   <= dy_i[DIFF_W-1] ? DIFF_W'(-dy_i) : DIFF_W'(dy_i);
      a1_r.ms   <= ms_i;

      a2_r  <= a1_r;
      sqx_r <= a1_r.bx * a1_r.bx;
      sqy_r <= a1_r.by * a1_r.by;

      a3_r  <= a2_r;
      sum_r <= RAD_W'(sqx_r) + RAD_W'(sqy_r);
    end
  end

  assign rt_vld[0]  = a3_vld_r;
  assign rt_n[0]    = sum_r;
  assign rt_r[0]    = '0;
  assign rt_side[0] = a3_r;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    sfu_sqrt_cell #(
      .RAD_W (RAD_W),
      .K     (ROOT_W - 1 - k),
      .SIDE_W(RT_W)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (rt_vld[k]),
      .n_i   (rt_n[k]),
      .r_i   (rt_r[k]),
      .side_i(rt_side[k]),
      .vld_o (rt_vld[k+1]),
      .n_o   (rt_n[k+1]),
      .r_o   (rt_r[k+1]),
      .side_o(rt_side[k+1])
    );
  end

  assign rt_out = rt_side[ROOT_W];

  always_ff @(posedge clk) begin
    if (en) begin
      a4_r.user <= rt_out.user;
      a4_r.nx   <= rt_out.nx;
      a4_r.ny   <= rt_out.ny;
      a4_r.ls   <= rt_r[ROOT_W][ROOT_W-1:0];
      pmx_r     <= rt_out.bx * rt_out.ms;
      pmy_r     <= rt_out.by * rt_out.ms;

      a5_r     <= a4_r;
      num_r[0] <= AIM_NUM_W'(pmx_r) + AIM_NUM_W'(a4_r.ls >> 1);
      num_r[1] <= AIM_NUM_W'(pmy_r) + AIM_NUM_W'(a4_r.ls >> 1);
    end
  end

  sfu_div #(
    .NUM_W (AIM_NUM_W),
    .DEN_W (ROOT_W),
    .QUO_W (QUO_W),
    .SIDE_W(DV_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (a5_vld_r),
    .num_i (num_r),
    .den_i (a5_r.ls),
    .side_i(a5_r),
    .vld_o (dv_vld),
    .quo_o (dv_quo),
    .side_o(dv_side)
  );

  assign dv_out = dv_side;

  // A zero distance leaves the desired velocity at zero.
  always_ff @(posedge clk) begin
    if (en) begin
      if (dv_out.ls == '0) begin
        wx_r <= '0;
        wy_r <= '0;
      end else begin
        wx_r <= dv_out.nx ? -VEL_W'(dv_quo[0]) : VEL_W'(dv_quo[0]);
        wy_r <= dv_out.ny ? -VEL_W'(dv_quo[1]) : VEL_W'(dv_quo[1]);
      end
      len_r  <= dv_out.ls;
      user_r <= dv_out.user;
    end
  end

  assign vld_o  = a6_vld_r;
  assign wx_o   = wx_r;
  assign wy_o   = wy_r;
  assign len_o  = len_r;
  assign side_o = user_r;

endmodule

FILE: src/steering_force_unit.sv
// Steering force unit: one agent per beat, seek with arrival, flee, pursuit
// and evade, giving one saturated 2-D force per agent. A new agent is taken
// in every cycle in which in_stall is low. The pipeline is built from the
// two distance square-root cell chains (26 cells each), the two direction
// divider chains (17 cells each), the arrival divider (17 cells) and the
// prediction divider (35 cells), plus glue register stages.
// The whole pipeline holds while a finished result is stalled at the output,
// so in_stall follows out_stall only while out_valid is high. The arrival
// radius register may be written at any time the block is idle; it resets to
// 100.0 in the fixed point format set by FRAC_BITS.
module steering_force_unit #(
  parameter int FRAC_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  sfu_pkg::in_beat_t            in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output sfu_pkg::out_beat_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sfu_pkg::RADIUS_W-1:0] cfg_data
);
  import sfu_pkg::*;

  localparam int SAT_W = OFS_W + 1;
  localparam int FRC_W = COORD_W + 2;
  localparam logic [PRED_Q_W-1:0] PRED_LIM = PRED_Q_W'(1) << (PRED_Q_W - 1);

  typedef struct packed {
    cmd_t                      cmd;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] tx;
    logic signed [COORD_W-1:0] ty;
    logic signed [COORD_W-1:0] tvx;
    logic signed [COORD_W-1:0] tvy;
    logic signed [COORD_W-1:0] svx;
    logic signed [COORD_W-1:0] svy;
    logic [SPEED_W-1:0]        ms;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic signed [VEL_W-1:0]   w1x;
    logic signed [VEL_W-1:0]   w1y;
    logic signed [VEL_W-1:0]   wax;
    logic signed [VEL_W-1:0]   way;
    logic [ROOT_W-1:0]         len1;
    logic                      arr;
    logic                      nax;
    logic                      nay;
    logic                      ntx;
    logic                      nty;
  } ctx_t;

  localparam int CTX_W = $bits(ctx_t);

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi, lo;
    hi = SAT_W'({1'b0, {(COORD_W-1){1'b1}}});
    lo = -hi - SAT_W'(1);
    if (v > hi) begin
      return hi[COORD_W-1:0];
    end else if (v < lo) begin
      return lo[COORD_W-1:0];
    end
    return v[COORD_W-1:0];
  endfunction

  logic                adv;
  logic [RADIUS_W-1:0] radius_r;

  logic  v0_r;
  ctx_t  c0_r, c0_nxt;

  logic                    a1_vld;
  logic signed [VEL_W-1:0] a1_wx, a1_wy;
  logic [ROOT_W-1:0]       a1_len;
  logic [CTX_W-1:0]        a1_side;
  ctx_t                    a1_ctx;

  logic                      v1_r;
  ctx_t                      c1_r, c1_nxt;
  logic [DIFF_W+SPEED_W-1:0] pax_r, pay_r;

  logic                      v2_r;
  ctx_t                      c2_r;
  logic [1:0][ARR_NUM_W-1:0] anum_r;

  logic                  ad_vld;
  logic [1:0][QUO_W-1:0] ad_quo;
  logic [CTX_W-1:0]      ad_side;
  ctx_t                  ad_ctx;

  logic                      v3_r;
  ctx_t                      c3_r, c3_nxt;
  logic [COORD_W+ROOT_W-1:0] ptx_r, pty_r;

  logic                       v4_r;
  ctx_t                       c4_r;
  logic [1:0]                 big_r;
  logic [1:0][PRED_NUM_W-1:0] pnum_r, pnum;

  logic                     pd_vld;
  logic [1:0][PRED_Q_W-1:0] pd_quo;
  logic [CTX_W+1:0]         pd_side;
  ctx_t                     pd_ctx;
  logic [1:0]               pd_big;

  logic                    v5_r;
  ctx_t                    c5_r;
  logic signed [OFS_W-1:0] offx_r, offy_r;

  logic                      v6_r;
  ctx_t                      c6_r;
  logic signed [COORD_W-1:0] px_r, py_r;

  logic                     v7_r;
  ctx_t                     c7_r;
  logic signed [DIFF_W-1:0] dx2_r, dy2_r;

  logic                    a2_vld;
  logic signed [VEL_W-1:0] a2_wx, a2_wy;
  logic [CTX_W-1:0]        a2_side;
  ctx_t                    a2_ctx;

  logic                    sel_neg;
  logic signed [VEL_W-1:0] selx, sely;
  logic signed [FRC_W-1:0] fx, fy;

  logic      out_valid_r;
  out_beat_t out_data_r;

  assign adv       = !(out_valid_r && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_W'(100 << FRAC_BITS);
    end else if (cfg_valid) begin
      radius_r <= cfg_data;
    end
  end

  always_comb begin
    c0_nxt     = '0;
    c0_nxt.cmd = in_data.command;
    c0_nxt.sx  = in_data.self_x;
    c0_nxt.sy  = in_data.self_y;
    c0_nxt.tx  = in_data.target_x;
    c0_nxt.ty  = in_data.target_y;
    c0_nxt.tvx = in_data.target_vx;
    c0_nxt.tvy = in_data.target_vy;
    c0_nxt.svx = in_data.self_vx;
    c0_nxt.svy = in_data.self_vy;
    c0_nxt.ms  = in_data.max_speed;
    c0_nxt.dx  = DIFF_W'(in_data.target_x) - DIFF_W'(in_data.self_x);
    c0_nxt.dy  = DIFF_W'(in_data.target_y) - DIFF_W'(in_data.self_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v0_r        <= in_valid;
      v1_r        <= a1_vld;
      v2_r        <= v1_r;
      v3_r        <= ad_vld;
      v4_r        <= v3_r;
      v5_r        <= pd_vld;
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      out_valid_r <= a2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c0_r <= c0_nxt;
    end
  end

  // Direction and distance to the target itself.
  sfu_aim #(
    .SIDE_W(CTX_W)
  ) u_aim_target (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vld_i (v0_r),
    .dx_i  (c0_r.dx),
    .dy_i  (c0_r.dy),
    .ms_i  (c0_r.ms),
    .side_i(c0_r),
    .vld_o (a1_vld),
    .wx_o  (a1_wx),
    .wy_o  (a1_wy),
    .len_o (a1_len),
    .side_o(a1_side)
  );

  assign a1_ctx = a1_side;

  always_comb begin
    c1_nxt      = a1_ctx;
    c1_nxt.w1x  = a1_wx;
    c1_nxt.w1y  = a1_wy;
    c1_nxt.len1 = a1_len;
    c1_nxt.arr  = (a1_ctx.cmd == CMD_SEEK) && (radius_r != '0) && (a1_len != '0) &&
                  (a1_len <= ROOT_W'(radius_r));
    c1_nxt.nax  = a1_ctx.dx[DIFF_W-1];
    c1_nxt.nay  = a1_ctx.dy[DIFF_W-1];
  end

  // Arrival numerators: |d| * speed, then the half-radius rounding term.
  always_ff @(posedge clk) begin
    if (adv) begin
      c1_r      <= c1_nxt;
      pax_r     <= (a1_ctx.dx[DIFF_W-1] ? DIFF_W'(-a1_ctx.dx) : DIFF_W'(a1_ctx.dx)) *
                   a1_ctx.ms;
      pay_r     <= (a1_ctx.dy[DIFF_W-1] ? DIFF_W'(-a1_ctx.dy) : DIFF_W'(a1_ctx.dy)) *
                   a1_ctx.ms;

      c2_r      <= c1_r;
      anum_r[0] <= ARR_NUM_W'(pax_r) + ARR_NUM_W'(radius_r >> 1);
      anum_r[1] <= ARR_NUM_W'(pay_r) + ARR_NUM_W'(radius_r >> 1);
    end
  end

  sfu_div #(
    .NUM_W (ARR_NUM_W),
    .DEN_W (RADIUS_W),
    .QUO_W (QUO_W),
    .SIDE_W(CTX_W)
  ) u_div_arrive (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vld_i (v2_r),
    .num_i (anum_r),
    .den_i (radius_r),
    .side_i(c2_r),
    .vld_o (ad_vld),
    .quo_o (ad_quo),
    .side_o(ad_side)
  );

  assign ad_ctx = ad_side;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      pnum[l] = PRED_NUM_W'(l == 0 ? ptx_r : pty_r) + PRED_NUM_W'(c3_r.ms >> 1);
    end
  end

  always_comb begin
    c3_nxt     = ad_ctx;
    c3_nxt.wax = ad_ctx.nax ? -VEL_W'(ad_quo[0]) : VEL_W'(ad_quo[0]);
    c3_nxt.way = ad_ctx.nay ? -VEL_W'(ad_quo[1]) : VEL_W'(ad_quo[1]);
    c3_nxt.ntx = ad_ctx.tvx[COORD_W-1];
    c3_nxt.nty = ad_ctx.tvy[COORD_W-1];
  end

  // Prediction: |tv| * distance over speed, rounded.
  always_ff @(posedge clk) begin
    if (adv) begin
      c3_r     <= c3_nxt;
      ptx_r    <= (ad_ctx.tvx[COORD_W-1] ? COORD_W'(-ad_ctx.tvx) : COORD_W'(ad_ctx.tvx)) *
                  ad_ctx.len1;
      pty_r    <= (ad_ctx.tvy[COORD_W-1] ? COORD_W'(-ad_ctx.tvy) : COORD_W'(ad_ctx.tvy)) *
                  ad_ctx.len1;

      c4_r     <= c3_r;
      pnum_r   <= pnum;
      // A quotient that would not fit the divider is past the clamp anyway.
      big_r[0] <= pnum[0] >= (PRED_NUM_W'(c3_r.ms) << PRED_Q_W);
      big_r[1] <= pnum[1] >= (PRED_NUM_W'(c3_r.ms) << PRED_Q_W);
    end
  end

  sfu_div #(
    .NUM_W (PRED_NUM_W),
    .DEN_W (SPEED_W),
    .QUO_W (PRED_Q_W),
    .SIDE_W(CTX_W + 2)
  ) u_div_predict (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vld_i (v4_r),
    .num_i (pnum_r),
    .den_i (c4_r.ms),
    .side_i({big_r, c4_r}),
    .vld_o (pd_vld),
    .quo_o (pd_quo),
    .side_o(pd_side)
  );

  assign pd_ctx = pd_side[CTX_W-1:0];
  assign pd_big = pd_side[CTX_W+1:CTX_W];

  always_ff @(posedge clk) begin
    if (adv) begin
      c5_r <= pd_ctx;
      // With no top speed the target position is used as it is.
      if (pd_ctx.ms == '0) begin
        offx_r <= '0;
        offy_r <= '0;
      end else begin
        offx_r <= (pd_big[0] || pd_quo[0] > PRED_LIM) ?
                  (pd_ctx.ntx ? -OFS_W'(PRED_LIM) : OFS_W'(PRED_LIM)) :
                  (pd_ctx.ntx ? -OFS_W'(pd_quo[0]) : OFS_W'(pd_quo[0]));
        offy_r <= (pd_big[1] || pd_quo[1] > PRED_LIM) ?
                  (pd_ctx.nty ? -OFS_W'(PRED_LIM) : OFS_W'(PRED_LIM)) :
                  (pd_ctx.nty ? -OFS_W'(pd_quo[1]) : OFS_W'(pd_quo[1]));
      end

      c6_r <= c5_r;
      px_r <= sat_coord(SAT_W'(c5_r.tx) + SAT_W'(offx_r));
      py_r <= sat_coord(SAT_W'(c5_r.ty) + SAT_W'(offy_r));

      c7_r  <= c6_r;
      dx2_r <= DIFF_W'(px_r) - DIFF_W'(c6_r.sx);
      dy2_r <= DIFF_W'(py_r) - DIFF_W'(c6_r.sy);
    end
  end

  // Direction to the predicted position.
  sfu_aim #(
    .SIDE_W(CTX_W)
  ) u_aim_predict (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vld_i (v7_r),
    .dx_i  (dx2_r),
    .dy_i  (dy2_r),
    .ms_i  (c7_r.ms),
    .side_i(c7_r),
    .vld_o (a2_vld),
    .wx_o  (a2_wx),
    .wy_o  (a2_wy),
    .len_o (),
    .side_o(a2_side)
  );

  assign a2_ctx = a2_side;

  always_comb begin
    sel_neg = (a2_ctx.cmd == CMD_FLEE) || (a2_ctx.cmd == CMD_EVADE);
    unique case (a2_ctx.cmd)
      CMD_PURSUIT, CMD_EVADE: begin
        selx = a2_wx;
        sely = a2_wy;
      end
      CMD_SEEK: begin
        selx = a2_ctx.arr ? a2_ctx.wax : a2_ctx.w1x;
        sely = a2_ctx.arr ? a2_ctx.way : a2_ctx.w1y;
      end
      default: begin
        selx = a2_ctx.w1x;
        sely = a2_ctx.w1y;
      end
    endcase
    fx = (sel_neg ? -FRC_W'(selx) : FRC_W'(selx)) - FRC_W'(a2_ctx.svx);
    fy = (sel_neg ? -FRC_W'(sely) : FRC_W'(sely)) - FRC_W'(a2_ctx.svy);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.force_x <= sat_coord(SAT_W'(fx));
      out_data_r.force_y <= sat_coord(SAT_W'(fy));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
